// ===== rtl/bsm_pkg.sv =====
// Shared types and constants for the bank switch mapper.
// Holds the decoded operation format passed from the front end to the back end.
// No dependencies.
package bsm_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam int ADDR_W = 16;
	localparam int DATA_W = 8;
	localparam int BANK_W = 12;
	localparam int CHR_COUNT = 8;
	localparam int CFG_DATA_W = 4;

	localparam logic signed [9:0] PRESCALE_PERIOD = 10'sd341;
	localparam logic signed [9:0] PRESCALE_STEP = 10'sd3;
	localparam logic [6:0] PRG_FIXED_HI = 7'h7F;   // fixed windows read 0xFE / 0xFF

	// Top address nibble of register regions
	localparam logic [3:0] REGION_PRG0 = 4'h8;
	localparam logic [3:0] REGION_MIRROR = 4'h9;
	localparam logic [3:0] REGION_PRG1 = 4'hA;
	localparam logic [3:0] REGION_CHR_FIRST = 4'hB;
	localparam logic [3:0] REGION_IRQ = 4'hF;

	// Register select codes
	localparam logic [1:0] SEL_0 = 2'd0;
	localparam logic [1:0] SEL_1 = 2'd1;
	localparam logic [1:0] SEL_2 = 2'd2;
	localparam logic [1:0] SEL_3 = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_A0_PIN = 2'd0;
	localparam logic [1:0] CFG_A1_PIN = 2'd1;
	localparam logic [1:0] CFG_FOUR_VARIANT = 2'd2;
	localparam logic [1:0] CFG_HONOR_REPEAT = 2'd3;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_TICK = 2'd1,
		ACT_PRG_QUERY = 2'd2,
		ACT_CHR_QUERY = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		OP_NONE = 4'd0,
		OP_TICK = 4'd1,
		OP_PRG_REG = 4'd2,
		OP_MIRROR = 4'd3,
		OP_MISC = 4'd4,
		OP_LATCH_LO = 4'd5,
		OP_LATCH_HI = 4'd6,
		OP_MODE = 4'd7,
		OP_ACK = 4'd8,
		OP_CHR_LO = 4'd9,
		OP_CHR_HI = 4'd10,
		OP_PRG_QUERY = 4'd11,
		OP_CHR_QUERY = 4'd12
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		logic [2:0] idx;   // register index or query window
		logic [DATA_W-1:0] data;
	} op_t;

	typedef struct packed {
		logic [3:0] a0_pin_bit;
		logic [3:0] a1_pin_bit;
		logic is_four_variant;
		logic honor_repeat_bit;
	} cfg_t;

endpackage

// ===== rtl/bsm_front.sv =====
// Front end: classifies an accepted item into a decoded operation.
// Decodes the board-wired select pins and register regions.
// Depends on bsm_pkg.
module bsm_front (
	input bsm_pkg::cfg_t cfg,
	input logic [1:0] action,
	input logic [bsm_pkg::ADDR_W-1:0] address,
	input logic [bsm_pkg::DATA_W-1:0] data,
	output bsm_pkg::op_t op
);

	logic [3:0] region;
	logic [1:0] sel;
	logic [3:0] chr_group;

	assign region = address[15:12];
	assign sel = {address[cfg.a1_pin_bit], address[cfg.a0_pin_bit]};
	assign chr_group = region - bsm_pkg::REGION_CHR_FIRST;

	always_comb begin
		op.kind = bsm_pkg::OP_NONE;
		op.idx = 3'd0;
		op.data = data;
		unique case (bsm_pkg::action_t'(action))
			bsm_pkg::ACT_TICK: begin
				op.kind = bsm_pkg::OP_TICK;
			end
			bsm_pkg::ACT_PRG_QUERY: begin
				op.kind = bsm_pkg::OP_PRG_QUERY;
				op.idx = {1'b0, address[14:13]};
			end
			bsm_pkg::ACT_CHR_QUERY: begin
				op.kind = bsm_pkg::OP_CHR_QUERY;
				op.idx = address[12:10];
			end
			bsm_pkg::ACT_WRITE: begin
				priority if (region == bsm_pkg::REGION_PRG0 || region == bsm_pkg::REGION_PRG1) begin
					op.kind = bsm_pkg::OP_PRG_REG;
					op.idx = {2'b00, region[1]};
				end else if (region == bsm_pkg::REGION_MIRROR) begin
					if (!cfg.is_four_variant || sel == bsm_pkg::SEL_0)
						op.kind = bsm_pkg::OP_MIRROR;
					else if (sel == bsm_pkg::SEL_2)
						op.kind = bsm_pkg::OP_MISC;
				end else if (region == bsm_pkg::REGION_IRQ) begin
					if (cfg.is_four_variant) begin
						unique case (sel)
							bsm_pkg::SEL_0: op.kind = bsm_pkg::OP_LATCH_LO;
							bsm_pkg::SEL_1: op.kind = bsm_pkg::OP_LATCH_HI;
							bsm_pkg::SEL_2: op.kind = bsm_pkg::OP_MODE;
							default: op.kind = bsm_pkg::OP_ACK;
						endcase
					end
				end else if (region >= bsm_pkg::REGION_CHR_FIRST) begin
					// two CHR registers per region, low nibble or high byte picked by A0
					op.kind = sel[0] ? bsm_pkg::OP_CHR_HI : bsm_pkg::OP_CHR_LO;
					op.idx = {chr_group[1:0], sel[1]};
				end else begin
					op.kind = bsm_pkg::OP_NONE;
				end
			end
			default: op.kind = bsm_pkg::OP_NONE;
		endcase
	end

endmodule

// ===== rtl/bsm_queue.sv =====
// Short queue of decoded operations between front end and back end.
// Lets each side stall on its own.
// Depends on bsm_pkg.
module bsm_queue #(
	parameter int DEPTH = bsm_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input bsm_pkg::op_t push_op,
	input logic pop,
	output bsm_pkg::op_t head_op,
	output logic full,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	bsm_pkg::op_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/bsm_back.sv =====
// Back end: applies decoded operations to the mapper state and builds results.
// Holds bank registers, IRQ unit and the output register.
// Depends on bsm_pkg.
module bsm_back (
	input logic clk,
	input logic arst_n,
	input bsm_pkg::cfg_t cfg,
	input logic op_valid,
	input bsm_pkg::op_t op,
	output logic op_take,
	output logic out_valid,
	input logic out_stall,
	output logic [bsm_pkg::BANK_W-1:0] bank,
	output logic [1:0] mirror_mode,
	output logic irq_line
);

	logic [7:0] prg_q [2];
	logic [bsm_pkg::BANK_W-1:0] chr_q [bsm_pkg::CHR_COUNT];
	logic [7:0] mirror_q;
	logic [7:0] misc_q;
	logic [7:0] reload_q;
	logic [2:0] mode_q;
	logic [7:0] counter_q;
	logic signed [9:0] prescaler_q;
	logic flag_q;
	logic out_valid_q;
	logic [bsm_pkg::BANK_W-1:0] bank_q;
	logic [1:0] mirror_mode_q;
	logic irq_line_q;

	logic [7:0] mirror_d;
	logic [7:0] reload_d;
	logic [2:0] mode_d;
	logic [7:0] counter_d;
	logic signed [9:0] prescaler_d;
	logic signed [9:0] prescaler_dec;
	logic flag_d;
	logic clock_counter;
	logic [1:0] window;
	logic [bsm_pkg::BANK_W-1:0] bank_d;
	logic [1:0] mirror_mode_d;

	assign op_take = op_valid && (!out_valid_q || !out_stall);
	assign prescaler_dec = prescaler_q - bsm_pkg::PRESCALE_STEP;

	// PRG window with optional swap of the first and third windows
	always_comb begin
		window = op.idx[1:0];
		if (!window[0] && misc_q[1])
			window = window ^ 2'b10;
	end

	always_comb begin
		mirror_d = mirror_q;
		reload_d = reload_q;
		mode_d = mode_q;
		counter_d = counter_q;
		prescaler_d = prescaler_q;
		flag_d = flag_q;
		clock_counter = 1'b0;
		bank_d = '0;
		unique case (op.kind)
			bsm_pkg::OP_MIRROR: mirror_d = op.data;
			bsm_pkg::OP_LATCH_LO: reload_d = {reload_q[7:4], op.data[3:0]};
			bsm_pkg::OP_LATCH_HI: reload_d = {op.data[3:0], reload_q[3:0]};
			bsm_pkg::OP_MODE: begin
				mode_d = op.data[2:0];
				if (op.data[1]) begin
					counter_d = reload_q;
					prescaler_d = bsm_pkg::PRESCALE_PERIOD;
				end
				flag_d = 1'b0;
			end
			bsm_pkg::OP_ACK: begin
				if (cfg.honor_repeat_bit)
					mode_d = {mode_q[2], mode_q[0], mode_q[0]};
				flag_d = 1'b0;
			end
			bsm_pkg::OP_TICK: begin
				if (cfg.is_four_variant && mode_q[1]) begin
					if (mode_q[2]) begin
						clock_counter = 1'b1;
					end else if (prescaler_dec > 10'sd0) begin
						prescaler_d = prescaler_dec;
					end else begin
						prescaler_d = prescaler_dec + bsm_pkg::PRESCALE_PERIOD;
						clock_counter = 1'b1;
					end
				end
				if (clock_counter) begin
					// reload and raise IRQ on wrap
					if (counter_q == 8'hFF) begin
						counter_d = reload_q;
						flag_d = 1'b1;
					end else begin
						counter_d = counter_q + 8'd1;
					end
				end
			end
			bsm_pkg::OP_PRG_QUERY: begin
				if (window[1])
					bank_d = {4'd0, bsm_pkg::PRG_FIXED_HI, window[0]};
				else
					bank_d = {4'd0, prg_q[window[0]]};
			end
			bsm_pkg::OP_CHR_QUERY: bank_d = chr_q[op.idx];
			default: bank_d = '0;
		endcase
	end

	always_comb begin
		if (cfg.is_four_variant && mirror_d[1])
			mirror_mode_d = {1'b1, mirror_d[0]};
		else
			mirror_mode_d = {1'b0, mirror_d[0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_q[0] <= '0;
			prg_q[1] <= '0;
			for (int i = 0; i < bsm_pkg::CHR_COUNT; i++)
				chr_q[i] <= bsm_pkg::BANK_W'(i);
			mirror_q <= '0;
			misc_q <= '0;
			reload_q <= '0;
			mode_q <= '0;
			counter_q <= '0;
			prescaler_q <= '0;
			flag_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (op_take) begin
				mirror_q <= mirror_d;
				reload_q <= reload_d;
				mode_q <= mode_d;
				counter_q <= counter_d;
				prescaler_q <= prescaler_d;
				flag_q <= flag_d;
				if (op.kind == bsm_pkg::OP_PRG_REG)
					prg_q[op.idx[0]] <= op.data;
				if (op.kind == bsm_pkg::OP_MISC)
					misc_q <= op.data;
				if (op.kind == bsm_pkg::OP_CHR_LO)
					chr_q[op.idx] <= {chr_q[op.idx][11:4], op.data[3:0]};
				if (op.kind == bsm_pkg::OP_CHR_HI)
					chr_q[op.idx] <= {op.data, chr_q[op.idx][3:0]};
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_take) begin
			bank_q <= bank_d;
			mirror_mode_q <= mirror_mode_d;
			irq_line_q <= flag_d;
		end
	end

	assign out_valid = out_valid_q;
	assign bank = bank_q;
	assign mirror_mode = mirror_mode_q;
	assign irq_line = irq_line_q;

endmodule

// ===== rtl/bank_switch_mapper_with_cpu_irq.sv =====
// Bank switch mapper with CPU-clocked IRQ counter: top level.
// Result path: an accepted item is queued, then taken from the queue head into the output register.
// Throughput: one item per cycle while out_stall is low, set by the back-end execute step.
// The operation queue holds QUEUE_DEPTH decoded items; input stalls only when it is full.
// Reset: asynchronous, clears all mapper state (CHR register i to i) and configuration
// to its defaults; output data registers are not reset; no clearing pass.
module bank_switch_mapper_with_cpu_irq #(
	parameter int QUEUE_DEPTH = bsm_pkg::QUEUE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [bsm_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] action,
	input logic [bsm_pkg::ADDR_W-1:0] address,
	input logic [bsm_pkg::DATA_W-1:0] data,
	output logic out_valid,
	input logic out_stall,
	output logic [bsm_pkg::BANK_W-1:0] bank,
	output logic [1:0] mirror_mode,
	output logic irq_line
);

	bsm_pkg::cfg_t cfg_q;
	bsm_pkg::op_t front_op;
	bsm_pkg::op_t head_op;
	logic q_full;
	logic q_empty;
	logic op_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a0_pin_bit <= 4'd0;
			cfg_q.a1_pin_bit <= 4'd1;
			cfg_q.is_four_variant <= 1'b1;
			cfg_q.honor_repeat_bit <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bsm_pkg::CFG_A0_PIN: cfg_q.a0_pin_bit <= cfg_data;
				bsm_pkg::CFG_A1_PIN: cfg_q.a1_pin_bit <= cfg_data;
				bsm_pkg::CFG_FOUR_VARIANT: cfg_q.is_four_variant <= cfg_data[0];
				default: cfg_q.honor_repeat_bit <= cfg_data[0];
			endcase
		end
	end

	assign in_stall = q_full;

	bsm_front u_front (
		.cfg(cfg_q),
		.action(action),
		.address(address),
		.data(data),
		.op(front_op)
	);

	bsm_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(in_valid),
		.push_op(front_op),
		.pop(op_take),
		.head_op(head_op),
		.full(q_full),
		.empty(q_empty)
	);

	bsm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.op_valid(!q_empty),
		.op(head_op),
		.op_take(op_take),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bank(bank),
		.mirror_mode(mirror_mode),
		.irq_line(irq_line)
	);

	// Executing a queued item always leaves a result waiting
	a_take_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		op_take |=> out_valid)
		else $error("executed item produced no result");

	// IRQ can only rise on a result produced by a CPU tick
	a_irq_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && $rose(irq_line)) |->
			$past(op_take && head_op.kind == bsm_pkg::OP_TICK))
		else $error("irq raised by an item other than a cpu tick");

	// Single-screen modes exist only on the four variant
	a_mirror_variant: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !cfg_q.is_four_variant) |-> !mirror_mode[1])
		else $error("single-screen mirroring reported without four variant");

endmodule
